// ===== src/playfair_digraph_encrypt_7x4_core_defines.svh =====
// Assertion macros used by the checker file of the Playfair pair encryption core.
// Depends on nothing; the including file supplies clock and reset names as arguments.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_7X4_CORE_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_7X4_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/plfr_pkg.sv =====
// Shared constants and types for the Playfair pair encryption core.
// Depends on nothing; used by the interfaces, the grid builder and the lookup stage.
`default_nettype none

package plfr_pkg;

  // Grid geometry and key size.
  localparam int GRID_ROWS = 7;
  localparam int GRID_COLS = 4;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int KEY_MAX   = 9;
  localparam int LETTERS   = 26;

  // Field widths.
  localparam int CHAR_W       = 8;
  localparam int CODE_W       = 5;
  localparam int KEY_W        = KEY_MAX * CODE_W;
  localparam int KEY_LEN_W    = 4;
  localparam int CFG_DATA_W   = KEY_W;
  localparam int CFG_IDX_W    = 1;
  localparam int POS_W        = $clog2(KEY_MAX + LETTERS + 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LETTERS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 1'd1;

  // Character constants.
  localparam logic [CHAR_W-1:0] CHAR_A       = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_STAR    = 8'h2a;
  localparam logic [CHAR_W-1:0] CHAR_HASH    = 8'h23;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0a;

  // The grid as held in registers: one byte and one occupied bit per cell,
  // cells in row-major order.
  typedef struct packed {
    logic [CELLS-1:0]             ok;
    logic [CELLS-1:0][CHAR_W-1:0] ch;
  } plfr_grid_t;

endpackage

`default_nettype wire

// ===== src/plfr_if.sv =====
// Valid/ready channel interfaces for the input pairs and the encrypted results.
// Depends on plfr_pkg for the character width.
`default_nettype none

interface plfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [plfr_pkg::CHAR_W-1:0] first_char;
  logic [plfr_pkg::CHAR_W-1:0] second_char;

  modport source (output valid, output first_char, output second_char, input ready);
  modport sink   (input valid, input first_char, input second_char, output ready);
endinterface

interface plfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [plfr_pkg::CHAR_W-1:0] cipher_first;
  logic [plfr_pkg::CHAR_W-1:0] cipher_second;
  logic                        not_in_grid;

  modport source (output valid, output cipher_first, output cipher_second,
                  output not_in_grid, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second,
                  input not_in_grid, output ready);
endinterface

`default_nettype wire

// ===== src/playfair_digraph_encrypt_7x4_core.sv =====
// Playfair pair encryption on a 7-row by 4-column grid. One plaintext pair is
// taken per clock cycle when the output is not stalled. Each pair passes
// through the input register, then through the grid search into the result
// register. The grid is rebuilt from the key registers into a grid register
// after any key write, so the first pair may follow the write in the next
// cycle. A character that is not in the grid raises not_in_grid and zeroes
// both cipher bytes.
// Depends on plfr_pkg, plfr_if.sv, plfr_grid and plfr_lookup.
`default_nettype none

module playfair_digraph_encrypt_7x4_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [plfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [plfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  plfr_in_if.sink                         in_i,
  plfr_out_if.source                      out_o
);
  import plfr_pkg::*;

  plfr_grid_t grid;

  // Key registers and the registered grid.
  plfr_grid u_grid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .grid_o     (grid)
  );

  // Two-stage encryption datapath.
  plfr_lookup u_lookup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .grid_i (grid),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ===== src/plfr_grid.sv =====
// Key registers and grid builder: holds the key and a registered copy of the grid.
// Depends on plfr_pkg.
`default_nettype none

module plfr_grid (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [plfr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [plfr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output plfr_pkg::plfr_grid_t                grid_o
);
  import plfr_pkg::*;

  logic [KEY_W-1:0]     key_letters_q;
  logic [KEY_LEN_W-1:0] key_length_q;
  plfr_grid_t           grid_d;
  plfr_grid_t           grid_q;

  // Key letters go first; each unused letter lands at key length plus the number
  // of unused letters below it; the last two cells are fixed.
  function automatic plfr_grid_t build_grid(input logic [KEY_W-1:0]     letters,
                                            input logic [KEY_LEN_W-1:0] length);
    plfr_grid_t              g;
    logic [KEY_LEN_W-1:0]    klen;
    logic [LETTERS-1:0]      used;
    logic [LETTERS-1:0]      unused;
    logic [LETTERS-1:0][POS_W-1:0] pos;
    logic [CODE_W-1:0]       code;
    klen = (length > KEY_LEN_W'(KEY_MAX)) ? KEY_LEN_W'(KEY_MAX) : length;
    used = '0;
    for (int i = 0; i < KEY_MAX; i++) begin
      code = letters[CODE_W*i +: CODE_W];
      for (int l = 0; l < LETTERS; l++) begin
        if ((KEY_LEN_W'(i) < klen) && (code == CODE_W'(l))) begin
          used[l] = 1'b1;
        end
      end
    end
    unused = ~used;
    for (int l = 0; l < LETTERS; l++) begin
      pos[l] = POS_W'(klen) +
               POS_W'($countones(unused & ((LETTERS'(1) << l) - LETTERS'(1))));
    end
    g = '0;
    for (int p = 0; p < CELLS; p++) begin
      if ((p < KEY_MAX) && (POS_W'(p) < POS_W'(klen))) begin
        g.ch[p] = CHAR_A + CHAR_W'(letters[CODE_W*p +: CODE_W]);
        g.ok[p] = 1'b1;
      end else begin
        for (int l = 0; l < LETTERS; l++) begin
          if (unused[l] && (pos[l] == POS_W'(p))) begin
            g.ch[p] = CHAR_A + CHAR_W'(l);
            g.ok[p] = 1'b1;
          end
        end
      end
    end
    g.ch[CELLS-2] = CHAR_STAR;
    g.ok[CELLS-2] = 1'b1;
    g.ch[CELLS-1] = CHAR_HASH;
    g.ok[CELLS-1] = 1'b1;
    return g;
  endfunction

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_letters_q <= '0;
      key_length_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_LETTERS: key_letters_q <= cfg_data_i[KEY_W-1:0];
        REG_KEY_LENGTH:  key_length_q  <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // The grid is rebuilt from the key registers and held in the grid register.
  assign grid_d = build_grid(key_letters_q, key_length_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= build_grid('0, '0);
    end else begin
      grid_q <= grid_d;
    end
  end

  assign grid_o = grid_q;

endmodule

`default_nettype wire

// ===== src/plfr_lookup.sv =====
// Input register, grid search and cipher selection, and the result register.
// Depends on plfr_pkg and the channel interfaces in plfr_if.sv.
`default_nettype none

module plfr_lookup (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  plfr_pkg::plfr_grid_t grid_i,
  plfr_in_if.sink              in_i,
  plfr_out_if.source           out_o
);
  import plfr_pkg::*;

  logic              s1_valid_q;
  logic [CHAR_W-1:0] s1_c1_q;
  logic [CHAR_W-1:0] s1_c2_q;
  logic              out_valid_q;
  logic [CHAR_W-1:0] out_c1_q;
  logic [CHAR_W-1:0] out_c2_q;
  logic              out_flag_q;

  logic              in_beat;
  logic              s2_ready;
  logic              s2_load;

  logic [CELLS-1:0]     hit1, hit2, m1, m2;
  logic [GRID_ROWS-1:0] rh1, rh2;
  logic [GRID_COLS-1:0] kh1, kh2;
  logic                 same_row, same_col, found;
  logic [CHAR_W-1:0]    row1, row2, col1, col2, rect1, rect2;
  logic [CHAR_W-1:0]    c1_d, c2_d;
  logic                 flag_d;

  // Handshake: the result register frees the input register, which frees the port.
  assign s2_ready  = !out_valid_q || out_o.ready;
  assign s2_load   = s1_valid_q && s2_ready;
  assign in_i.ready = !s1_valid_q || s2_ready;
  assign in_beat   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_beat) begin
        s1_valid_q <= 1'b1;
      end else if (s2_ready) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Input register; a newline in the second character stands for '#'.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_c1_q <= in_i.first_char;
      s1_c2_q <= (in_i.second_char == CHAR_NEWLINE) ? CHAR_HASH : in_i.second_char;
    end
  end

  // Find the last matching cell of each character, then pick the cipher pair.
  always_comb begin
    int p;
    int rn;
    int cn;
    for (int i = 0; i < CELLS; i++) begin
      hit1[i] = grid_i.ok[i] && (grid_i.ch[i] == s1_c1_q);
      hit2[i] = grid_i.ok[i] && (grid_i.ch[i] == s1_c2_q);
    end
    for (int i = 0; i < CELLS; i++) begin
      m1[i] = hit1[i] && !(|(hit1 >> (i + 1)));
      m2[i] = hit2[i] && !(|(hit2 >> (i + 1)));
    end
    rh1 = '0;
    rh2 = '0;
    kh1 = '0;
    kh2 = '0;
    row1 = '0;
    row2 = '0;
    col1 = '0;
    col2 = '0;
    rect1 = '0;
    rect2 = '0;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        p = r * GRID_COLS + c;
        rh1[r] = rh1[r] | m1[p];
        rh2[r] = rh2[r] | m2[p];
        kh1[c] = kh1[c] | m1[p];
        kh2[c] = kh2[c] | m2[p];
      end
    end
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        p  = r * GRID_COLS + c;
        rn = (r == GRID_ROWS - 1) ? 0 : r + 1;
        cn = (c == GRID_COLS - 1) ? 0 : c + 1;
        row1  = row1  | (m1[p] ? grid_i.ch[r * GRID_COLS + cn] : '0);
        row2  = row2  | (m2[p] ? grid_i.ch[r * GRID_COLS + cn] : '0);
        col1  = col1  | (m1[p] ? grid_i.ch[rn * GRID_COLS + c] : '0);
        col2  = col2  | (m2[p] ? grid_i.ch[rn * GRID_COLS + c] : '0);
        rect1 = rect1 | ((rh1[r] && kh2[c]) ? grid_i.ch[p] : '0);
        rect2 = rect2 | ((rh2[r] && kh1[c]) ? grid_i.ch[p] : '0);
      end
    end
    found    = (|hit1) && (|hit2);
    same_row = |(rh1 & rh2);
    same_col = |(kh1 & kh2);
    flag_d   = !found;
    if (!found) begin
      c1_d = '0;
      c2_d = '0;
    end else if (same_row) begin
      c1_d = row1;
      c2_d = row2;
    end else if (same_col) begin
      c1_d = col1;
      c2_d = col2;
    end else begin
      c1_d = rect1;
      c2_d = rect2;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      out_c1_q   <= c1_d;
      out_c2_q   <= c2_d;
      out_flag_q <= flag_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cipher_first  = out_c1_q;
  assign out_o.cipher_second = out_c2_q;
  assign out_o.not_in_grid   = out_flag_q;

endmodule

`default_nettype wire

// ===== src/plfr_checker.sv =====
// Port-level checks for the Playfair pair encryption core, bound to the top level.
// Depends on playfair_digraph_encrypt_7x4_core_defines.svh.
`default_nettype none
`include "playfair_digraph_encrypt_7x4_core_defines.svh"

module plfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] cipher_first_i,
  input logic [7:0] cipher_second_i,
  input logic       not_in_grid_i
);

  // A stalled result beat stays offered.
  `PLFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A pair missing from the grid carries zero cipher bytes.
  `PLFR_ASSERT_IMPLY(a_flag_zero, clk_i, rst_ni, out_valid_i && not_in_grid_i, (cipher_first_i == 8'h00) && (cipher_second_i == 8'h00))

  // With the output empty the input side is never stalled.
  `PLFR_ASSERT_IMPLY(a_ready_free, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // A result that appears on an empty output came from an input beat that passed straight through the input register.
  `PLFR_ASSERT_IMPLY(a_latency, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2))

endmodule

bind playfair_digraph_encrypt_7x4_core plfr_checker u_plfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .cipher_first_i  (out_o.cipher_first),
  .cipher_second_i (out_o.cipher_second),
  .not_in_grid_i   (out_o.not_in_grid)
);

`default_nettype wire

// ===== dv/playfair_digraph_encrypt_7x4_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 7x4 Playfair pair encryption core.
// Depends on plfr_pkg, the plfr_in_if/plfr_out_if interfaces and the core itself.

import plfr_pkg::*;

typedef struct packed {
  logic [CHAR_W-1:0] first;
  logic [CHAR_W-1:0] second;
  logic              absent;
} cipher_pair_t;

// Keeps its own copy of the key registers and grid, predicts the cipher pair
// of every accepted plaintext beat and checks result beats in order.
class plfr_cipher_scoreboard;
  logic [KEY_W-1:0]     key_letters;
  logic [KEY_LEN_W-1:0] key_length;
  plfr_grid_t           grid;
  cipher_pair_t         cipher_q[$];
  int unsigned          errors;
  int unsigned          pairs, row_hits, col_hits, rect_hits, absent_hits, key_loads;

  function new();
    key_letters = '0;
    key_length  = '0;
    errors      = 0;
    pairs       = 0;
    row_hits    = 0;
    col_hits    = 0;
    rect_hits   = 0;
    absent_hits = 0;
    key_loads   = 0;
    rebuild_grid();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_KEY_LETTERS) begin
      key_letters = data[KEY_W-1:0];
    end else if (idx == REG_KEY_LENGTH) begin
      key_length = data[KEY_LEN_W-1:0];
    end
    rebuild_grid();
  endfunction

  // Key letters first, then the letters the key leaves free, then '*' and '#'.
  function void rebuild_grid();
    bit              used[LETTERS];
    int unsigned     klen;
    int unsigned     nxt;
    logic [CODE_W-1:0] code;
    klen = (key_length > KEY_MAX) ? KEY_MAX : key_length;
    nxt  = 0;
    foreach (used[i]) used[i] = 1'b0;
    for (int unsigned i = 0; i < klen; i++) begin
      code = key_letters[CODE_W*i +: CODE_W];
      if (code < LETTERS) used[code] = 1'b1;
    end
    for (int unsigned p = 0; p < CELLS; p++) begin
      grid.ch[p] = '0;
      grid.ok[p] = 1'b0;
      if (p < klen) begin
        grid.ch[p] = CHAR_A + CHAR_W'(key_letters[CODE_W*p +: CODE_W]);
        grid.ok[p] = 1'b1;
      end else begin
        while (nxt < LETTERS && used[nxt]) nxt++;
        if (nxt < LETTERS) begin
          grid.ch[p] = CHAR_A + CHAR_W'(nxt);
          grid.ok[p] = 1'b1;
          nxt++;
        end
      end
    end
    grid.ch[CELLS-2] = CHAR_STAR;
    grid.ok[CELLS-2] = 1'b1;
    grid.ch[CELLS-1] = CHAR_HASH;
    grid.ok[CELLS-1] = 1'b1;
  endfunction

  // The last matching cell in row-major order wins.
  function bit find_cell(logic [CHAR_W-1:0] ch, output int unsigned row,
                         output int unsigned col);
    bit found;
    found = 1'b0;
    row   = 0;
    col   = 0;
    for (int unsigned p = 0; p < CELLS; p++) begin
      if (grid.ok[p] && grid.ch[p] == ch) begin
        row   = p / GRID_COLS;
        col   = p % GRID_COLS;
        found = 1'b1;
      end
    end
    return found;
  endfunction

  function logic [CHAR_W-1:0] cell_at(int unsigned row, int unsigned col);
    return grid.ch[row * GRID_COLS + col];
  endfunction

  function cipher_pair_t encrypt_pair(logic [CHAR_W-1:0] c1, logic [CHAR_W-1:0] c2_in);
    cipher_pair_t      res;
    logic [CHAR_W-1:0] c2;
    int unsigned       r1, k1, r2, k2;
    bit                f1, f2;
    c2  = (c2_in == CHAR_NEWLINE) ? CHAR_HASH : c2_in;
    f1  = find_cell(c1, r1, k1);
    f2  = find_cell(c2, r2, k2);
    res = '0;
    if (!f1 || !f2) begin
      res.absent = 1'b1;
      absent_hits++;
    end else if (r1 == r2) begin
      res.first  = cell_at(r1, (k1 + 1) % GRID_COLS);
      res.second = cell_at(r1, (k2 + 1) % GRID_COLS);
      row_hits++;
    end else if (k1 == k2) begin
      res.first  = cell_at((r1 + 1) % GRID_ROWS, k1);
      res.second = cell_at((r2 + 1) % GRID_ROWS, k1);
      col_hits++;
    end else begin
      res.first  = cell_at(r1, k2);
      res.second = cell_at(r2, k1);
      rect_hits++;
    end
    return res;
  endfunction

  function void note_pair(logic [CHAR_W-1:0] c1, logic [CHAR_W-1:0] c2);
    cipher_q.push_back(encrypt_pair(c1, c2));
    pairs++;
  endfunction

  function void check_result(logic [CHAR_W-1:0] cf, logic [CHAR_W-1:0] cs, logic nig);
    cipher_pair_t exp;
    if (cipher_q.size() == 0) begin
      $error("unexpected result beat: cipher_first %h cipher_second %h not_in_grid %b",
             cf, cs, nig);
      errors++;
      return;
    end
    exp = cipher_q.pop_front();
    if (cf !== exp.first) begin
      $error("cipher_first: expected %h, actual %h", exp.first, cf);
      errors++;
    end
    if (cs !== exp.second) begin
      $error("cipher_second: expected %h, actual %h", exp.second, cs);
      errors++;
    end
    if (nig !== exp.absent) begin
      $error("not_in_grid: expected %b, actual %b", exp.absent, nig);
      errors++;
    end
  endfunction
endclass

module playfair_digraph_encrypt_7x4_core_tb;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 82;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN       = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    gaps_on;
  int unsigned           stall_left;
  int unsigned           quiet_cycles;
  logic [KEY_W-1:0]      new_letters;
  logic [KEY_LEN_W-1:0]  new_length;
  logic [CHAR_W-1:0]     p1, p2;

  plfr_cipher_scoreboard sb = new();

  plfr_in_if  in_bus ();
  plfr_out_if out_bus ();

  playfair_digraph_encrypt_7x4_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side back-pressure in short random bursts; held low during reset.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 2);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Beat monitor and watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        sb.note_pair(in_bus.first_char, in_bus.second_char);
      end
      if (out_bus.valid && out_bus.ready) begin
        sb.check_result(out_bus.cipher_first, out_bus.cipher_second, out_bus.not_in_grid);
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Drive one plaintext beat; starts and ends on a falling edge.
  task automatic send_pair(input logic [CHAR_W-1:0] c1, input logic [CHAR_W-1:0] c2);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap          = $urandom_range(1, 3);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.first_char  <= c1;
    in_bus.second_char <= c2;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off new pairs until every predicted result has come back.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(negedge clk_i); while (sb.cipher_q.size() != 0);
  endtask

  // Write both key registers on back-to-back cycles.
  task automatic load_key(input logic [KEY_W-1:0] letters, input logic [KEY_LEN_W-1:0] length);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_KEY_LETTERS;
    cfg_data <= letters;
    @(negedge clk_i);
    cfg_idx  <= REG_KEY_LENGTH;
    cfg_data <= CFG_DATA_W'(length);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    sb.write_reg(REG_KEY_LETTERS, letters);
    sb.write_reg(REG_KEY_LENGTH, CFG_DATA_W'(length));
    sb.key_loads++;
  endtask

  function automatic logic [KEY_W-1:0] key_from_text(input string s);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < KEY_MAX; i++) begin
      k[CODE_W*i +: CODE_W] = CODE_W'(s[i] - CHAR_A);
    end
    return k;
  endfunction

  // Mostly distinct-letter keys; sometimes raw bits with an oversized length.
  function automatic void random_key(output logic [KEY_W-1:0] letters,
                                     output logic [KEY_LEN_W-1:0] length);
    int unsigned perm[LETTERS];
    int unsigned j, tmp;
    if ($urandom_range(0, 3) == 0) begin
      letters = KEY_W'({$urandom, $urandom});
      length  = KEY_LEN_W'($urandom_range(0, 15));
    end else begin
      foreach (perm[i]) perm[i] = i;
      for (int i = LETTERS - 1; i > 0; i--) begin
        j       = $urandom_range(0, i);
        tmp     = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      letters = '0;
      for (int i = 0; i < KEY_MAX; i++) letters[CODE_W*i +: CODE_W] = CODE_W'(perm[i]);
      length = KEY_LEN_W'($urandom_range(0, KEY_MAX));
    end
  endfunction

  // Pairs drawn from the current grid, biased toward shared rows and columns,
  // with some newlines and arbitrary bytes mixed in.
  function automatic void pick_pair(output logic [CHAR_W-1:0] c1, output logic [CHAR_W-1:0] c2);
    int unsigned a, b, mode;
    a    = $urandom_range(0, CELLS - 1);
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      b = (a / GRID_COLS) * GRID_COLS + $urandom_range(0, GRID_COLS - 1);
    end else if (mode < 4) begin
      b = $urandom_range(0, GRID_ROWS - 1) * GRID_COLS + a % GRID_COLS;
    end else begin
      b = $urandom_range(0, CELLS - 1);
    end
    c1 = sb.grid.ch[a];
    c2 = sb.grid.ch[b];
    if (c2 == CHAR_HASH && $urandom_range(0, 2) == 0) c2 = CHAR_NEWLINE;
    if ($urandom_range(0, 9) == 0) c1 = CHAR_W'($urandom);
    if ($urandom_range(0, 9) == 0) c2 = CHAR_W'($urandom);
  endfunction

  initial begin
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= '0;
    cfg_data           <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.first_char  <= '0;
    in_bus.second_char <= '0;
    stall_left         = 0;
    quiet_cycles       = 0;
    gaps_on            = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default grid a..z, '*', '#': row, column, rectangle, wraps and misses.
    send_pair("a", "b");
    send_pair("d", "a");
    send_pair("a", "e");
    send_pair("y", "a");
    send_pair("a", "f");
    send_pair("a", "a");
    send_pair("a", CHAR_NEWLINE);
    send_pair(CHAR_NEWLINE, "a");
    send_pair(CHAR_STAR, CHAR_HASH);
    send_pair("A", "b");
    send_pair("b", 8'hff);
    send_pair(8'h00, 8'h00);
    send_pair(8'hff, 8'hff);

    // Oversized length, repeated letters and a code past 'z'.
    wait_drained();
    load_key(key_from_text("zebra|zqa"), 4'd15);
    send_pair("z", "q");
    send_pair("|", "a");
    send_pair("w", "c");
    send_pair("a", "a");

    // Every key code at its maximum.
    wait_drained();
    load_key('1, KEY_LEN_W'(KEY_MAX));
    send_pair(8'h80, 8'h80);
    send_pair(8'h80, "q");
    send_pair("r", "b");

    // Random phases, each under a fresh key; the last one runs without idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          new_letters = KEY_W'({$urandom, $urandom});
          new_length  = '0;
        end
        1: begin
          new_letters = '0;
          new_length  = KEY_LEN_W'(KEY_MAX);
        end
        default: random_key(new_letters, new_length);
      endcase
      load_key(new_letters, new_length);
      gaps_on = (ph != 6 && ph != PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 4 && i == PHASE_ITEMS / 2) wait_drained();
        pick_pair(p1, p2);
        send_pair(p1, p2);
      end
    end

    wait_drained();
    repeat (DRAIN) @(negedge clk_i);
    if (sb.cipher_q.size() != 0) begin
      $error("%0d predicted results never arrived", sb.cipher_q.size());
      sb.errors++;
    end
    $display("Encrypted %0d pairs under %0d keys: %0d same-row, %0d same-column,",
             sb.pairs, sb.key_loads + 1, sb.row_hits, sb.col_hits);
    $display("%0d rectangle and %0d with a character outside the grid.",
             sb.rect_hits, sb.absent_hits);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
